// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the top-level design file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== design/sfc_pkg.sv =====
// ---------------------------------------------------------------------------
// sfc_pkg
// Shared constants, types and helpers of the stereo FIR convolver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

  localparam int TAPS_DEFAULT = 210;
  localparam int LANES        = 2;

  localparam int SAMPLE_W     = 16;
  localparam int GAIN_W       = 16;
  localparam int TAP_IDX_W    = 8;
  localparam int REG_INDEX_W  = 1;

  localparam int GAIN_FRAC    = 12;
  localparam int COEF_FRAC    = 15;
  localparam int SCALE_SHIFT  = GAIN_FRAC + COEF_FRAC;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8650;

  // Configuration register indexes
  localparam logic [REG_INDEX_W-1:0] REG_BYPASS = 1'b0;
  localparam logic [REG_INDEX_W-1:0] REG_GAIN   = 1'b1;

  // Input item kinds
  localparam logic KIND_AUDIO = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  // Per-tap control from the sequencer to every lane
  typedef struct packed {
    logic clear;    // start of an item: zero the accumulator
    logic issue;    // read one tap this cycle
    logic hist_ok;  // the history word read holds a real sample
    logic last;     // final tap of the item
  } lane_ctrl_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== design/sfc_ram.sv =====
// ---------------------------------------------------------------------------
// sfc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfc_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = sfc_pkg::TAPS_DEFAULT,
  localparam int AW    = sfc_pkg::addr_w(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/sfc_lane.sv =====
// ---------------------------------------------------------------------------
// sfc_lane
// One channel: history and coefficient RAMs, a multiply-accumulate, and
// the gain, truncation and saturation stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfc_lane #(
  parameter int  TAPS   = sfc_pkg::TAPS_DEFAULT,
  localparam int ADDR_W = sfc_pkg::addr_w(TAPS)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire sfc_pkg::lane_ctrl_t                 ctrl,
  input  wire logic                                hist_wr_en,
  input  wire logic [ADDR_W-1:0]                   hist_wr_addr,
  input  wire logic signed [sfc_pkg::SAMPLE_W-1:0] hist_wr_data,
  input  wire logic [ADDR_W-1:0]                   hist_rd_addr,
  input  wire logic                                coef_wr_en,
  input  wire logic [ADDR_W-1:0]                   coef_wr_addr,
  input  wire logic signed [sfc_pkg::SAMPLE_W-1:0] coef_wr_data,
  input  wire logic [ADDR_W-1:0]                   coef_rd_addr,
  input  wire logic [sfc_pkg::GAIN_W-1:0]          gain,
  output logic signed [sfc_pkg::SAMPLE_W-1:0]      result,
  output logic                                     done
);

  localparam int SW    = sfc_pkg::SAMPLE_W;
  localparam int PW    = 2 * SW;
  localparam int ACC_W = PW + $clog2(TAPS);
  localparam int LO_W  = 16;
  localparam int HI_W  = ACC_W - LO_W;
  localparam int PH_W  = HI_W + sfc_pkg::GAIN_W + 1;
  localparam int PL_W  = LO_W + sfc_pkg::GAIN_W;
  localparam int SC_W  = PH_W + LO_W;
  localparam int SH    = sfc_pkg::SCALE_SHIFT;
  localparam int QW    = SC_W - SH;

  localparam logic signed [SC_W-1:0] TRUNC_BIAS = SC_W'((64'd1 << SH) - 64'd1);
  localparam logic [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

  logic [SW-1:0] hist_rd;
  logic [SW-1:0] coef_rd;

  sfc_ram #(.WIDTH(SW), .DEPTH(TAPS)) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_wr_en),
    .wr_addr (hist_wr_addr),
    .wr_data (hist_wr_data),
    .rd_en   (ctrl.issue),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd)
  );

  sfc_ram #(.WIDTH(SW), .DEPTH(TAPS)) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_wr_en),
    .wr_addr (coef_wr_addr),
    .wr_data (coef_wr_data),
    .rd_en   (ctrl.issue),
    .rd_addr (coef_rd_addr),
    .rd_data (coef_rd)
  );

  sfc_pkg::lane_ctrl_t    s1;
  logic                   s2_issue;
  logic                   s2_last;
  logic                   sa;
  logic                   sb;
  logic                   sc;

  logic signed [SW-1:0]   hist_term;
  logic signed [SW-1:0]   coef_term;
  logic signed [PW-1:0]   prod;
  logic signed [ACC_W-1:0] acc;

  logic signed [HI_W-1:0] acc_hi;
  logic [LO_W-1:0]        acc_lo;
  logic signed [sfc_pkg::GAIN_W:0] gain_s;
  logic signed [PH_W-1:0] p_hi;
  logic [PL_W-1:0]        p_lo;
  logic signed [SC_W-1:0] hi_ext;
  logic signed [SC_W-1:0] lo_ext;
  logic signed [SC_W-1:0] scaled;
  logic signed [SC_W-1:0] biased;
  logic signed [QW-1:0]   quot;
  logic                   in_range;

  // Unfilled history slots read as zero
  assign hist_term = s1.hist_ok ? signed'(hist_rd) : '0;
  assign coef_term = signed'(coef_rd);

  assign acc_hi = acc[ACC_W-1:LO_W];
  assign acc_lo = acc[LO_W-1:0];
  assign gain_s = signed'({1'b0, gain});

  assign hi_ext = {p_hi, {LO_W{1'b0}}};
  assign lo_ext = signed'({{(SC_W-PL_W){1'b0}}, p_lo});

  // Truncate toward zero: bias negative values before the shift
  assign biased   = scaled + (scaled[SC_W-1] ? TRUNC_BIAS : '0);
  assign quot     = biased[SC_W-1:SH];
  assign in_range = (&quot[QW-1:SW-1]) || (~|quot[QW-1:SW-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1       <= '0;
      s2_issue <= 1'b0;
      s2_last  <= 1'b0;
      sa       <= 1'b0;
      sb       <= 1'b0;
      sc       <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1       <= ctrl;
      s2_issue <= s1.issue;
      s2_last  <= s1.last;
      sa       <= s2_issue && s2_last;
      sb       <= sa;
      sc       <= sb;
      done     <= sc;
    end
  end

  always_ff @(posedge clk) begin
    if (s1.issue) begin
      prod <= coef_term * hist_term;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (s2_issue) begin
      acc <= acc + {{(ACC_W-PW){prod[PW-1]}}, prod};
    end
    if (sa) begin
      p_hi <= acc_hi * gain_s;
      p_lo <= acc_lo * gain;
    end
    if (sb) begin
      scaled <= hi_ext + lo_ext;
    end
    if (sc) begin
      result <= in_range ? quot[SW-1:0] : (quot[QW-1] ? SAT_MIN : SAT_MAX);
    end
  end

endmodule

`default_nettype wire

// ===== design/sfc_seq.sv =====
// ---------------------------------------------------------------------------
// sfc_seq
// Tap sequencer: delay-line pointers, fill count and per-tap control
// shared by both lanes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfc_seq #(
  parameter int  TAPS   = sfc_pkg::TAPS_DEFAULT,
  localparam int ADDR_W = sfc_pkg::addr_w(TAPS),
  localparam int CNT_W  = $clog2(TAPS + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept_audio,
  input  wire logic                lanes_done,
  input  wire logic                out_free,
  output logic                     busy,
  output logic                     push,
  output sfc_pkg::lane_ctrl_t      ctrl,
  output logic [ADDR_W-1:0]        hist_wr_addr,
  output logic [ADDR_W-1:0]        hist_rd_addr,
  output logic [ADDR_W-1:0]        coef_rd_addr
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_PUSH = 4'b1000
  } seq_state_t;

  localparam logic [CNT_W-1:0]  LAST_TAP = CNT_W'(TAPS - 1);
  localparam logic [CNT_W-1:0]  FULL     = CNT_W'(TAPS);
  localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(TAPS - 1);

  seq_state_t        state;
  seq_state_t        state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] head_next;
  logic [ADDR_W-1:0] rd_ptr;

  always_comb begin
    state_next = state;
    push       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept_audio) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cnt == LAST_TAP) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (lanes_done) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        // hold the lane results until the output register is free
        if (out_free) begin
          push       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign head_next = (head == TOP_ADDR) ? '0 : head + ADDR_W'(1);
  assign fill_next = (fill == FULL) ? fill : fill + CNT_W'(1);

  assign ctrl.clear   = accept_audio;
  assign ctrl.issue   = (state == ST_RUN);
  assign ctrl.hist_ok = (cnt < fill);
  assign ctrl.last    = (cnt == LAST_TAP);

  assign hist_wr_addr = head;
  assign hist_rd_addr = rd_ptr;
  assign coef_rd_addr = cnt[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      fill   <= '0;
      head   <= '0;
      rd_ptr <= '0;
    end else begin
      state <= state_next;
      if (accept_audio) begin
        cnt    <= '0;
        rd_ptr <= head;
        head   <= head_next;
        fill   <= fill_next;
      end else if (state == ST_RUN) begin
        cnt    <= cnt + CNT_W'(1);
        // walk from the newest sample back to the oldest
        rd_ptr <= (rd_ptr == '0) ? TOP_ADDR : rd_ptr - ADDR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/stereo_fir_convolver_top.sv =====
// ---------------------------------------------------------------------------
// stereo_fir_convolver_top
// Stereo direct-form FIR with per-channel coefficients, output gain,
// saturation and bypass.
// ---------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  kind channel tap_index coef_value
//                                             left_in right_in
//   output    out        out_valid/out_stall  left_out right_out
//   config    in         wr_en                wr_index wr_data
//
// An audio transaction holds the input stalled from acceptance until its result
// is pushed to the output register; each lane reads one history and one
// coefficient RAM word per cycle while filtering. A coefficient load does not stall.
// Reset clears control only; the delay lines read as zero through a fill
// count, so no clearing pass runs. Coefficients are undefined until loaded.
// A result waits in the output register under stall while the next
// transaction is accepted and filtered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stereo_fir_convolver_top #(
  parameter int  TAPS   = sfc_pkg::TAPS_DEFAULT,
  localparam int ADDR_W = sfc_pkg::addr_w(TAPS)
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   wr_en,
  input  wire logic [sfc_pkg::REG_INDEX_W-1:0]        wr_index,
  input  wire logic [sfc_pkg::GAIN_W-1:0]             wr_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   kind,
  input  wire logic                                   channel,
  input  wire logic [sfc_pkg::TAP_IDX_W-1:0]          tap_index,
  input  wire logic signed [sfc_pkg::SAMPLE_W-1:0]    coef_value,
  input  wire logic signed [sfc_pkg::SAMPLE_W-1:0]    left_in,
  input  wire logic signed [sfc_pkg::SAMPLE_W-1:0]    right_in,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [sfc_pkg::SAMPLE_W-1:0]         left_out,
  output logic signed [sfc_pkg::SAMPLE_W-1:0]         right_out
);

  localparam int SW = sfc_pkg::SAMPLE_W;

  logic                   bypass;
  logic [sfc_pkg::GAIN_W-1:0] output_gain;

  logic                   accept;
  logic                   accept_audio;
  logic                   accept_load;
  logic                   tap_ok;
  logic [ADDR_W-1:0]      load_addr;
  logic                   out_free;
  logic                   busy;
  logic                   push;
  logic                   lanes_done;

  sfc_pkg::lane_ctrl_t    ctrl;
  logic [ADDR_W-1:0]      hist_wr_addr;
  logic [ADDR_W-1:0]      hist_rd_addr;
  logic [ADDR_W-1:0]      coef_rd_addr;

  logic signed [SW-1:0]   lane_sample [sfc_pkg::LANES];
  logic signed [SW-1:0]   lane_result [sfc_pkg::LANES];
  logic [sfc_pkg::LANES-1:0] lane_done;
  logic signed [SW-1:0]   held_left;
  logic signed [SW-1:0]   held_right;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass      <= 1'b0;
      output_gain <= sfc_pkg::GAIN_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        sfc_pkg::REG_BYPASS: bypass      <= wr_data[0];
        sfc_pkg::REG_GAIN:   output_gain <= wr_data;
        default: ;
      endcase
    end
  end

  assign in_stall     = busy;
  assign accept       = in_valid && !in_stall;
  assign accept_audio = accept && (kind == sfc_pkg::KIND_AUDIO);
  assign accept_load  = accept && (kind == sfc_pkg::KIND_LOAD);
  // drop loads beyond the last tap
  assign tap_ok       = {{(32-sfc_pkg::TAP_IDX_W){1'b0}}, tap_index} < 32'(TAPS);
  assign load_addr    = ADDR_W'(tap_index);
  assign out_free     = !out_valid || !out_stall;
  assign lanes_done   = &lane_done;

  assign lane_sample[0] = left_in;
  assign lane_sample[1] = right_in;

  sfc_seq #(.TAPS(TAPS)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept_audio (accept_audio),
    .lanes_done   (lanes_done),
    .out_free     (out_free),
    .busy         (busy),
    .push         (push),
    .ctrl         (ctrl),
    .hist_wr_addr (hist_wr_addr),
    .hist_rd_addr (hist_rd_addr),
    .coef_rd_addr (coef_rd_addr)
  );

  for (genvar g = 0; g < sfc_pkg::LANES; g++) begin : g_lane
    logic coef_we;

    assign coef_we = accept_load && tap_ok && (int'(channel) == g);

    sfc_lane #(.TAPS(TAPS)) u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .hist_wr_en   (accept_audio),
      .hist_wr_addr (hist_wr_addr),
      .hist_wr_data (lane_sample[g]),
      .hist_rd_addr (hist_rd_addr),
      .coef_wr_en   (coef_we),
      .coef_wr_addr (load_addr),
      .coef_wr_data (coef_value),
      .coef_rd_addr (coef_rd_addr),
      .gain         (output_gain),
      .result       (lane_result[g]),
      .done         (lane_done[g])
    );
  end

  // Keep the input samples for bypass
  always_ff @(posedge clk) begin
    if (accept_audio) begin
      held_left  <= left_in;
      held_right <= right_in;
    end
  end

  // Merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      left_out  <= bypass ? held_left  : lane_result[0];
      right_out <= bypass ? held_right : lane_result[1];
    end
  end

  `ASSERT_IMPLY(a_lanes_in_step, clk, rst, |lane_done, &lane_done)
  `ASSERT_IMPLY(a_done_while_busy, clk, rst, lane_done[0], in_stall)
  `ASSERT_IMPLY(a_push_when_free, clk, rst, push, !out_valid || !out_stall)
  `ASSERT_NEXT(a_audio_blocks_input, clk, rst, accept_audio, in_stall)

endmodule

`default_nettype wire

// ===== dv/stereo_fir_convolver_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stereo_fir_convolver_top_tb
// Self-checking bench for the stereo FIR convolver. Loads coefficient sets,
// streams sample pairs under random back-pressure on both channels and
// compares every stereo result with a tap-by-tap convolution kept alongside.
// ---------------------------------------------------------------------------
module stereo_fir_convolver_top_tb;
  import sfc_pkg::*;

  localparam int TAPS          = TAPS_DEFAULT;
  localparam int SETTLE_CYCLES = TAPS + 16;
  localparam int LONG_HOLD     = 1000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 130;
  localparam int REPORT_MAX    = 10;
  localparam int CYCLE_LIMIT   = 2000000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_pair_t;

  class reverb_tracker;
    logic                       bypass_on;
    logic [GAIN_W-1:0]          gain;
    logic signed [SAMPLE_W-1:0] history [LANES][TAPS];
    logic signed [SAMPLE_W-1:0] coefs   [LANES][TAPS];
    stereo_pair_t               due_pairs [$];
    int                         n_samples;
    int                         n_loads;
    int                         n_checked;
    int                         n_errors;

    function new();
      bypass_on = 1'b0;
      gain      = GAIN_RESET;
      foreach (history[c, t]) begin
        history[c][t] = '0;
        coefs[c][t]   = '0;
      end
      n_samples = 0;
      n_loads   = 0;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    function void set_reg(input logic [REG_INDEX_W-1:0] idx, input logic [GAIN_W-1:0] data);
      if (idx == REG_BYPASS) begin
        bypass_on = data[0];
      end else begin
        gain = data;
      end
    endfunction

    // Exact Q.15 sum, Q4.12 gain, truncate toward zero, saturate to 16 bits
    function logic signed [SAMPLE_W-1:0] convolve_lane(input int c);
      longint acc;
      longint q;
      bit     neg;
      acc = 0;
      for (int t = 0; t < TAPS; t++)
        acc += longint'(coefs[c][t]) * longint'(history[c][t]);
      q   = acc * longint'(gain);
      neg = (q < 0);
      if (neg) q = -q;
      q = q >> SCALE_SHIFT;
      if (neg) q = -q;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[SAMPLE_W-1:0];
    endfunction

    function void note_transaction(input logic k, input logic ch,
                                   input logic [TAP_IDX_W-1:0] tap,
                                   input logic signed [SAMPLE_W-1:0] cv,
                                   input logic signed [SAMPLE_W-1:0] lv,
                                   input logic signed [SAMPLE_W-1:0] rv);
      stereo_pair_t pair;
      if (k == KIND_LOAD) begin
        n_loads++;
        // drop loads aimed past the last tap
        if (tap < TAPS) coefs[ch][tap] = cv;
      end else begin
        n_samples++;
        for (int t = TAPS - 1; t > 0; t--) begin
          history[0][t] = history[0][t-1];
          history[1][t] = history[1][t-1];
        end
        history[0][0] = lv;
        history[1][0] = rv;
        if (bypass_on) begin
          pair.left  = lv;
          pair.right = rv;
        end else begin
          pair.left  = convolve_lane(0);
          pair.right = convolve_lane(1);
        end
        due_pairs.push_back(pair);
      end
    endfunction

    function void check_pair(input logic signed [SAMPLE_W-1:0] lv,
                             input logic signed [SAMPLE_W-1:0] rv);
      stereo_pair_t want;
      if (due_pairs.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("unexpected result: left %0d right %0d", lv, rv);
      end else begin
        want = due_pairs.pop_front();
        n_checked++;
        if (lv !== want.left || rv !== want.right) begin
          n_errors++;
          if (n_errors <= REPORT_MAX)
            $display("mismatch on result %0d: left exp %0d got %0d, right exp %0d got %0d",
                     n_checked, want.left, lv, want.right, rv);
        end
      end
    endfunction

    function int pending();
      return due_pairs.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       wr_en;
  logic [REG_INDEX_W-1:0]     wr_index;
  logic [GAIN_W-1:0]          wr_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       kind;
  logic                       channel;
  logic [TAP_IDX_W-1:0]       tap_index;
  logic signed [SAMPLE_W-1:0] coef_value;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  reverb_tracker tracker;
  int            gap_odds   = 0;
  int            stall_odds = 0;
  bit            hold_long  = 1'b0;
  int            n_settings = 0;
  int            cycles     = 0;

  stereo_fir_convolver_top #(.TAPS(TAPS)) dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .channel    (channel),
    .tap_index  (tap_index),
    .coef_value (coef_value),
    .left_in    (left_in),
    .right_in   (right_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .left_out   (left_out),
    .right_out  (right_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Output side: random stall bursts, plus one long hold to back the block up
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_pair(left_out, right_out);
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_value(input int span);
    int v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom_range(0, 2 * span) - span;
      3:       v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      4:       v = 0;
      default: v = $urandom;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_item(input logic k, input logic ch, input logic [TAP_IDX_W-1:0] tap,
                           input logic signed [SAMPLE_W-1:0] cv,
                           input logic signed [SAMPLE_W-1:0] lv,
                           input logic signed [SAMPLE_W-1:0] rv);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    channel    <= ch;
    tap_index  <= tap;
    coef_value <= cv;
    left_in    <= lv;
    right_in   <= rv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_transaction(k, ch, tap, cv, lv, rv);
  endtask

  task automatic send_load(input logic ch, input int tap, input logic signed [SAMPLE_W-1:0] cv);
    send_item(KIND_LOAD, ch, tap[TAP_IDX_W-1:0], cv, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic send_audio(input logic signed [SAMPLE_W-1:0] lv,
                            input logic signed [SAMPLE_W-1:0] rv);
    send_item(KIND_AUDIO, 1'($urandom_range(0, 1)), TAP_IDX_W'($urandom),
              SAMPLE_W'($urandom), lv, rv);
  endtask

  // Hold off until every result is in, then let any trailing load finish
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic bypass_val, input logic [GAIN_W-1:0] gain_val);
    wr_en    <= 1'b1;
    wr_index <= REG_BYPASS;
    wr_data  <= {{(GAIN_W-1){1'b0}}, bypass_val};
    @(posedge clk);
    tracker.set_reg(REG_BYPASS, {{(GAIN_W-1){1'b0}}, bypass_val});
    wr_index <= REG_GAIN;
    wr_data  <= gain_val;
    @(posedge clk);
    tracker.set_reg(REG_GAIN, gain_val);
    wr_en <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    logic [GAIN_W-1:0] g;
    tracker    = new();
    rst        <= 1'b1;
    wr_en      <= 1'b0;
    wr_index   <= REG_BYPASS;
    wr_data    <= '0;
    in_valid   <= 1'b0;
    kind       <= KIND_AUDIO;
    channel    <= 1'b0;
    tap_index  <= '0;
    coef_value <= '0;
    left_in    <= '0;
    right_in   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    n_settings = 1;

    // Full-scale coefficient set: left all positive, right all negative
    gap_odds   = 4;
    stall_odds = 6;
    for (int t = 0; t < TAPS; t++) begin
      send_load(1'b0, t, 16'sh7FFF);
      send_load(1'b1, t, 16'sh8000);
    end

    // Directed checks at reset settings: dropped out-of-range loads, saturation both ways, truncation
    send_load(1'b0, TAPS, 16'sh0000);
    send_load(1'b1, 255, 16'sh1234);
    send_audio(16'sh7FFF, 16'sh7FFF);
    send_audio(16'sh8000, 16'sh8000);
    send_audio(16'sh0000, 16'sh0000);
    send_audio(-16'sd1, 16'sd1);
    send_load(1'b0, 0, 16'sh8000);
    send_load(1'b1, TAPS - 1, 16'sh7FFF);
    send_audio(16'sd1, -16'sd1);
    settle();

    configure(1'b1, GAIN_RESET);
    send_audio(16'sh7FFF, 16'sh8000);
    send_audio(16'sh8000, 16'sh7FFF);
    send_audio(16'sh0000, -16'sd1);
    settle();

    configure(1'b0, 16'h0000);
    send_audio(16'sh7FFF, 16'sh8000);
    send_audio(16'sd123, -16'sd456);
    settle();

    configure(1'b0, 16'hFFFF);
    send_audio(16'sh8000, 16'sh7FFF);
    send_audio(16'sd5, -16'sd5);
    settle();

    configure(1'b0, 16'h0001);
    send_audio(16'sd300, -16'sd300);
    settle();

    // Mixed-magnitude coefficient set for the random part
    for (int t = 0; t < TAPS; t++) begin
      send_load(1'b0, t, pick_value(127));
      send_load(1'b1, t, pick_value(127));
    end
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       g = GAIN_RESET;
        2:       g = 16'h0001;
        4:       g = 16'hFFFF;
        5:       g = GAIN_W'($urandom_range(0, 4096));
        7:       g = GAIN_RESET;
        default: g = GAIN_W'($urandom);
      endcase
      configure(p == 3, g);
      if (p == PHASES - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else if (p % 3 == 2) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = $urandom_range(3, 10);
        stall_odds = $urandom_range(3, 10);
      end
      if (p == 1) hold_long = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 6) == 0) begin
          send_load(1'($urandom_range(0, 1)),
                    ($urandom_range(0, 15) == 0) ? $urandom_range(TAPS, 255)
                                                 : $urandom_range(0, TAPS - 1),
                    pick_value(127));
        end else begin
          send_audio(pick_value(300), pick_value(300));
        end
      end
      settle();
    end

    $display("Covered %0d sample pairs and %0d coefficient loads across %0d register settings,",
             tracker.n_samples, tracker.n_loads, n_settings);
    $display("with %0d stereo results compared and %0d mismatches.",
             tracker.n_checked, tracker.n_errors);
    if (tracker.n_errors == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
